// ===== design/ble_pkg.sv =====
// shared types and constants for the bouncing level envelope
// channel state entry, configuration set and register indexes; no dependencies
package ble_pkg;

    localparam int CHANNELS_DEF = 512;

    localparam int CH_W     = 9;
    localparam int FADER_W  = 8;
    localparam int LEVEL_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_BASE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_INCREMENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REBOUND_LOSS    = 2'd2;

    localparam logic [LEVEL_W-1:0] STEP_BASE_RST       = 16'd64;
    localparam logic [LEVEL_W-1:0] SPEED_INCREMENT_RST = 16'd16;
    localparam logic [LEVEL_W-1:0] REBOUND_LOSS_RST    = 16'd4096;

    // peak only ever takes a fader value and then shrinks, so 16 bits hold it
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] speed;
        logic [LEVEL_W-1:0] peak;
        logic               rising;
    } t_entry;

    typedef struct packed {
        logic [LEVEL_W-1:0] step_base;
        logic [LEVEL_W-1:0] speed_increment;
        logic [LEVEL_W-1:0] rebound_loss;
    } t_cfg;

endpackage

// ===== design/bouncing_level_envelope.sv =====
// bouncing level envelope top level: state memory, update stage, output register
// depends on ble_pkg, ble_state_mem, ble_update
//
// Input channel (i_in_valid / o_in_stall) takes one tick for one lighting
// channel per beat: channel index, fader byte, floor level and capture flag.
// Output channel (o_out_valid / i_out_stall) returns one beat per input beat,
// in order: the channel index, the new Q0.16 level and the settled flag.
// Configuration port (i_cfg_valid / o_cfg_ready, always ready) writes
// step_base (0), speed_increment (1) and rebound_loss (2); other indexes
// are ignored. Write it only while no beat is in flight.
// A beat passes the state read and the update stage to the output register.
// One beat per cycle is sustained while the output is not stalled: the state
// is read as the beat is taken, then updated and written back in the update
// stage, with the just-written entry forwarded when the same channel follows.
// After reset the memory is cleared one entry per cycle with o_in_stall high.
// A stalled output holds its beat; one more input beat then sits in the
// update stage and further input is stalled until the output drains.
// Channels at or above CHANNELS return level 0, not settled, with no update.
module bouncing_level_envelope #(
    parameter int CHANNELS = ble_pkg::CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ble_pkg::CH_W-1:0]            i_channel,
    input  logic [ble_pkg::FADER_W-1:0]         i_fader_level,
    input  logic [ble_pkg::LEVEL_W-1:0]         i_floor_level,
    input  logic                                i_capture,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ble_pkg::CH_W-1:0]            o_channel_out,
    output logic [ble_pkg::LEVEL_W-1:0]         o_level_out,
    output logic                                o_settled,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ble_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ble_pkg::LEVEL_W-1:0]         i_cfg_data
);

    localparam int  CH_SPAN = 1 << ble_pkg::CH_W;
    localparam int  DEPTH   = (CHANNELS > CH_SPAN) ? CH_SPAN : CHANNELS;
    localparam int  AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam bit  FULL    = (CHANNELS >= CH_SPAN);
    localparam logic [ble_pkg::CH_W-1:0] CH_LIMIT =
        ble_pkg::CH_W'((CHANNELS >= CH_SPAN) ? (CH_SPAN - 1) : CHANNELS);

    ble_pkg::t_cfg   r_cfg;
    ble_pkg::t_entry rd_data;
    ble_pkg::t_entry cur;
    ble_pkg::t_entry upd;
    ble_pkg::t_entry r_fwd_data;
    logic            r_fwd_hit;
    logic            upd_settled;
    logic            mem_busy;

    logic                          r_s1_valid;
    logic [ble_pkg::CH_W-1:0]      r_s1_ch;
    logic [AW-1:0]                 r_s1_addr;
    logic                          r_s1_in_range;
    logic [ble_pkg::FADER_W-1:0]   r_s1_fader;
    logic [ble_pkg::LEVEL_W-1:0]   r_s1_floor;
    logic                          r_s1_cap;

    logic                          r_out_valid;
    logic [ble_pkg::CH_W-1:0]      r_out_ch;
    logic [ble_pkg::LEVEL_W-1:0]   r_out_level;
    logic                          r_out_settled;

    logic          in_accept;
    logic          out_free;
    logic          s1_fire;
    logic          in_range;
    logic [AW-1:0] in_addr;

    assign in_addr    = i_channel[AW-1:0];
    assign in_range   = FULL ? 1'b1 : (i_channel < CH_LIMIT);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_stall = mem_busy || (r_s1_valid && !out_free);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_base       <= ble_pkg::STEP_BASE_RST;
            r_cfg.speed_increment <= ble_pkg::SPEED_INCREMENT_RST;
            r_cfg.rebound_loss    <= ble_pkg::REBOUND_LOSS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ble_pkg::REG_STEP_BASE:       r_cfg.step_base       <= i_cfg_data;
                ble_pkg::REG_SPEED_INCREMENT: r_cfg.speed_increment <= i_cfg_data;
                ble_pkg::REG_REBOUND_LOSS:    r_cfg.rebound_loss    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ble_state_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_addr (in_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_fire && r_s1_in_range),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (upd),
        .o_busy    (mem_busy)
    );

    // the read issued in the write-back cycle sees the old entry
    assign cur = r_fwd_hit ? r_fwd_data : rd_data;

    ble_update u_upd (
        .i_cur     (cur),
        .i_cfg     (r_cfg),
        .i_fader   (r_s1_fader),
        .i_floor   (r_s1_floor),
        .i_capture (r_s1_cap),
        .o_next    (upd),
        .o_settled (upd_settled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
            r_fwd_hit  <= s1_fire && r_s1_in_range && (r_s1_addr == in_addr);
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ch       <= i_channel;
            r_s1_addr     <= in_addr;
            r_s1_in_range <= in_range;
            r_s1_fader    <= i_fader_level;
            r_s1_floor    <= i_floor_level;
            r_s1_cap      <= i_capture;
            r_fwd_data    <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_ch      <= r_s1_ch;
            r_out_level   <= r_s1_in_range ? upd.level : '0;
            r_out_settled <= r_s1_in_range && upd_settled;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_channel_out = r_out_ch;
    assign o_level_out   = r_out_level;
    assign o_settled     = r_out_settled;

endmodule

// ===== design/ble_state_mem.sv =====
// per-channel state memory with one read and one write port, registered read
// runs a clearing pass after reset; uses ble_pkg
module ble_state_mem #(
    parameter int DEPTH = ble_pkg::CHANNELS_DEF,
    parameter int AW    = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output ble_pkg::t_entry     o_rd_data,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  ble_pkg::t_entry     i_wr_data,
    output logic                o_busy
);

    ble_pkg::t_entry r_mem [DEPTH];
    ble_pkg::t_entry r_rd_data;
    logic            r_busy;
    logic [AW-1:0]   r_clr_addr;
    logic [AW-1:0]   n_clr_addr;
    logic            n_busy;

    always_comb begin
        n_clr_addr = r_clr_addr;
        n_busy     = r_busy;
        if (r_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                n_busy = 1'b0;
            end else begin
                n_clr_addr = r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_busy     <= n_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

// ===== design/ble_update.sv =====
// one tick of the bounce for one channel: capture, fall or rise, floor clamp
// combinational; uses ble_pkg types
module ble_update (
    input  ble_pkg::t_entry                  i_cur,
    input  ble_pkg::t_cfg                    i_cfg,
    input  logic [ble_pkg::FADER_W-1:0]      i_fader,
    input  logic [ble_pkg::LEVEL_W-1:0]      i_floor,
    input  logic                             i_capture,
    output ble_pkg::t_entry                  o_next,
    output logic                             o_settled
);

    logic [15:0] fader_q;
    logic        take;
    logic [15:0] l0;
    logic [15:0] s0;
    logic [15:0] p0;
    logic        d0;
    logic [16:0] move;
    logic [17:0] diff;
    logic [17:0] sum;
    logic [16:0] spd_sum;
    logic [16:0] peak_sub;
    logic [15:0] lv;
    logic [15:0] spd;
    logic [15:0] pk;
    logic        dir;

    always_comb begin
        // byte * 257 is the byte repeated in both halves
        fader_q  = {i_fader, i_fader};
        take     = i_capture && (fader_q > i_cur.level);
        l0       = take ? fader_q : i_cur.level;
        s0       = take ? 16'd0 : i_cur.speed;
        p0       = take ? fader_q : i_cur.peak;
        d0       = take ? 1'b0 : i_cur.rising;
        move     = {1'b0, i_cfg.step_base} + {1'b0, s0};
        diff     = {2'b00, l0} - {1'b0, move};
        sum      = {2'b00, l0} + {1'b0, move};
        spd_sum  = {1'b0, s0} + {1'b0, i_cfg.speed_increment};
        peak_sub = {1'b0, p0} - {1'b0, i_cfg.rebound_loss};
        lv       = l0;
        spd      = s0;
        pk       = p0;
        dir      = d0;
        o_settled = 1'b0;

        if (!d0) begin
            if ($signed(diff) <= $signed({2'b00, i_floor})) begin
                lv  = i_floor;
                pk  = peak_sub[16] ? 16'd0 : peak_sub[15:0];
                dir = 1'b1;
                spd = i_cfg.speed_increment;
            end else begin
                lv  = diff[15:0];
                spd = spd_sum[16] ? 16'hFFFF : spd_sum[15:0];
            end
        end else begin
            if (sum > {2'b00, p0}) begin
                lv  = p0;
                dir = 1'b0;
                spd = i_cfg.speed_increment;
            end else begin
                lv  = sum[15:0];
            end
        end

        if (lv < i_floor) begin
            lv        = i_floor;
            o_settled = !i_capture;
        end

        o_next.level  = lv;
        o_next.speed  = spd;
        o_next.peak   = pk;
        o_next.rising = dir;
    end

endmodule

// ===== design/ble_checker.sv =====
// port-level checks for bouncing_level_envelope, bound to the top level
// depends on ble_pkg
module ble_checker #(
    parameter int CHANNELS = ble_pkg::CHANNELS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [ble_pkg::CH_W-1:0]      o_channel_out,
    input logic [ble_pkg::LEVEL_W-1:0]   o_level_out,
    input logic                          o_settled
);

    // a held output beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_level_out)
            && $stable(o_channel_out) && $stable(o_settled))
        else $error("output beat changed while stalled");

    // the clearing pass keeps input stalled right after reset
    a_clear_stall: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("input not stalled after reset");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    // channels beyond the configured count report zero and not settled
    a_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_channel_out >= CHANNELS) |-> (o_level_out == '0) && !o_settled)
        else $error("out-of-range channel gave a level");

endmodule

bind bouncing_level_envelope ble_checker #(
    .CHANNELS (CHANNELS)
) u_ble_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_channel_out (o_channel_out),
    .o_level_out   (o_level_out),
    .o_settled     (o_settled)
);

// ===== verif/bouncing_level_envelope_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for bouncing_level_envelope: directed table, then random ticks
// with an in-bench per-channel bounce predictor; depends on ble_pkg and the block's rtl

module bouncing_level_envelope_tb;

    localparam int CH_W      = ble_pkg::CH_W;
    localparam int FADER_W   = ble_pkg::FADER_W;
    localparam int LEVEL_W   = ble_pkg::LEVEL_W;
    localparam int CFG_IDX_W = ble_pkg::CFG_IDX_W;

    localparam int CHANNELS = ble_pkg::CHANNELS_DEF;
    localparam int HOT = 4;
    localparam int HOT_W = 2;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int PHASES = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 10;

    typedef struct {
        logic [CH_W-1:0]    channel;
        logic [FADER_W-1:0] fader;
        logic [LEVEL_W-1:0] floor_lvl;
        logic               capture;
    } t_tick;

    typedef struct {
        logic [CH_W-1:0]    channel;
        logic [LEVEL_W-1:0] level;
        logic               settled;
    } t_level_res;

    typedef struct {
        t_tick      t;
        bit         typed;
        t_level_res want;
    } t_dir_row;

    bit                    i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [CH_W-1:0]       i_channel;
    logic [FADER_W-1:0]    i_fader_level;
    logic [LEVEL_W-1:0]    i_floor_level;
    logic                  i_capture;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [CH_W-1:0]       o_channel_out;
    logic [LEVEL_W-1:0]    o_level_out;
    logic                  o_settled;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [LEVEL_W-1:0]    i_cfg_data;

    // predictor copy of the per-channel state and the registers
    logic [LEVEL_W-1:0] lvl_mem   [CHANNELS];
    logic [LEVEL_W-1:0] speed_mem [CHANNELS];
    int                 peak_mem  [CHANNELS];
    bit                 rise_mem  [CHANNELS];
    logic [LEVEL_W-1:0] cfg_step;
    logic [LEVEL_W-1:0] cfg_inc;
    logic [LEVEL_W-1:0] cfg_loss;

    t_level_res     due_levels [$];
    t_dir_row       dir_rows   [$];
    logic [CH_W-1:0]    hot_ch    [HOT];
    logic [LEVEL_W-1:0] hot_floor [HOT];

    int mismatches;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;

    bouncing_level_envelope uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_channel     (i_channel),
        .i_fader_level (i_fader_level),
        .i_floor_level (i_floor_level),
        .i_capture     (i_capture),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_channel_out (o_channel_out),
        .o_level_out   (o_level_out),
        .o_settled     (o_settled),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_level_res bounce_step(input t_tick t);
        t_level_res r;
        int  lvl;
        int  spd;
        int  pk;
        int  mv;
        int  fl;
        int  fd;
        bit  rising;
        r.channel = t.channel;
        r.level   = '0;
        r.settled = 1'b0;
        if (int'(t.channel) >= CHANNELS)
            return r;
        lvl    = int'(lvl_mem[t.channel]);
        spd    = int'(speed_mem[t.channel]);
        pk     = peak_mem[t.channel];
        rising = rise_mem[t.channel];
        fd     = int'(t.fader) * 257;
        fl     = int'(t.floor_lvl);
        if (t.capture && fd > lvl) begin
            lvl    = fd;
            spd    = 0;
            pk     = fd;
            rising = 1'b0;
        end
        mv = int'(cfg_step) + spd;
        if (!rising) begin
            lvl = lvl - mv;
            spd = spd + int'(cfg_inc);
            if (spd > 65535)
                spd = 65535;
            if (lvl <= fl) begin
                // floor contact: lose some peak and head back up
                lvl    = fl;
                pk     = pk - int'(cfg_loss);
                if (pk < 0)
                    pk = 0;
                rising = 1'b1;
                spd    = int'(cfg_inc);
            end
        end else begin
            lvl = lvl + mv;
            if (lvl > pk) begin
                lvl    = pk;
                rising = 1'b0;
                spd    = int'(cfg_inc);
            end
        end
        if (lvl < fl) begin
            lvl       = fl;
            r.settled = !t.capture;
        end
        lvl_mem[t.channel]   = lvl[LEVEL_W-1:0];
        speed_mem[t.channel] = spd[LEVEL_W-1:0];
        peak_mem[t.channel]  = pk;
        rise_mem[t.channel]  = rising;
        r.level = lvl[LEVEL_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_tick(input t_tick t, input bit typed, input t_level_res want);
        t_level_res pred;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_channel     <= t.channel;
        i_fader_level <= t.fader;
        i_floor_level <= t.floor_lvl;
        i_capture     <= t.capture;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pred = bounce_step(t);
        due_levels.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    // four beats back to back, the last to the unused index
    task automatic load_config(input logic [LEVEL_W-1:0] step, input logic [LEVEL_W-1:0] inc,
                               input logic [LEVEL_W-1:0] loss);
        logic [LEVEL_W-1:0] vals [4];
        int k;
        vals[0] = step;
        vals[1] = inc;
        vals[2] = loss;
        vals[3] = LEVEL_W'($urandom_range(0, 65535));
        for (k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= k[CFG_IDX_W-1:0];
            i_cfg_data  <= vals[CFG_IDX_W'(k)];
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            case (k[CFG_IDX_W-1:0])
                ble_pkg::REG_STEP_BASE:       cfg_step = vals[CFG_IDX_W'(k)];
                ble_pkg::REG_SPEED_INCREMENT: cfg_inc  = vals[CFG_IDX_W'(k)];
                ble_pkg::REG_REBOUND_LOSS:    cfg_loss = vals[CFG_IDX_W'(k)];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (due_levels.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic add_row(input int ch, input int fd, input int fl, input bit cap,
                           input bit typed, input int lvl, input bit stl);
        t_dir_row row;
        row.t.channel      = CH_W'(ch);
        row.t.fader        = FADER_W'(fd);
        row.t.floor_lvl    = LEVEL_W'(fl);
        row.t.capture      = cap;
        row.typed          = typed;
        row.want.channel   = CH_W'(ch);
        row.want.level     = LEVEL_W'(lvl);
        row.want.settled   = stl;
        dir_rows.push_back(row);
    endtask

    task automatic pick_hot_channels();
        int h;
        for (h = 0; h < HOT; h++) begin
            hot_ch[HOT_W'(h)]    = CH_W'($urandom_range(0, CHANNELS - 1));
            hot_floor[HOT_W'(h)] = LEVEL_W'(($urandom_range(0, 99) < 80) ?
                                            $urandom_range(0, 8000) :
                                            $urandom_range(0, 65535));
        end
    endtask

    // mostly long runs on a few channels with a steady floor, the rest noise
    function automatic t_tick random_tick();
        t_tick t;
        int h;
        if ($urandom_range(0, 99) < 75) begin
            h = $urandom_range(0, HOT - 1);
            if ($urandom_range(0, 99) < 3)
                hot_floor[HOT_W'(h)] = LEVEL_W'($urandom_range(0, 65535));
            t.channel   = hot_ch[HOT_W'(h)];
            t.floor_lvl = hot_floor[HOT_W'(h)];
            t.capture   = ($urandom_range(0, 99) < 8);
            t.fader     = FADER_W'($urandom_range(0, 255));
        end else begin
            t.channel   = CH_W'($urandom_range(0, 511));
            t.fader     = FADER_W'($urandom_range(0, 255));
            t.floor_lvl = LEVEL_W'($urandom_range(0, 65535));
            t.capture   = 1'($urandom_range(0, 1));
        end
        return t;
    endfunction

    always @(posedge i_clk) begin : out_check
        t_level_res want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (due_levels.size() == 0) begin
                flag_mismatch("unexpected beat, channel", int'(o_channel_out), -1);
            end else begin
                want = due_levels.pop_front();
                if (o_channel_out !== want.channel)
                    flag_mismatch("channel_out", int'(o_channel_out), int'(want.channel));
                if (o_level_out !== want.level)
                    flag_mismatch("level_out", int'(o_level_out), int'(want.level));
                if (o_settled !== want.settled)
                    flag_mismatch("settled", int'(o_settled), int'(want.settled));
            end
        end
    end

    initial begin : out_stall_drive
        int k;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) begin
                    i_out_stall <= 1'b1;
                    @(negedge i_clk);
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial begin : run_limit
        #4000000;
        $display("FAIL");
        $finish;
    end

    initial begin : main_seq
        int c;
        int ph;
        int n;
        t_level_res none;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_channel     = '0;
        i_fader_level = '0;
        i_floor_level = '0;
        i_capture     = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = ble_pkg::REG_STEP_BASE;
        i_cfg_data    = '0;
        none          = '{default: '0};
        mismatches    = 0;
        hold_req      = 1'b0;
        send_idle_pct = 12;
        recv_stall_pct = 87;
        cfg_step = ble_pkg::STEP_BASE_RST;
        cfg_inc  = ble_pkg::SPEED_INCREMENT_RST;
        cfg_loss = ble_pkg::REBOUND_LOSS_RST;
        for (c = 0; c < CHANNELS; c++) begin
            lvl_mem[CH_W'(c)]   = '0;
            speed_mem[CH_W'(c)] = '0;
            peak_mem[CH_W'(c)]  = 0;
            rise_mem[CH_W'(c)]  = 1'b0;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows at reset register values
        add_row(0,   0,   0,     0, 1, 0,     0);  // fresh channel falls onto a zero floor
        add_row(1,   255, 0,     1, 1, 65471, 0);  // full-scale capture, one step down
        add_row(1,   255, 0,     1, 1, 65471, 0);  // fader above level again recaptures
        add_row(1,   0,   0,     0, 0, 0,     0);
        add_row(511, 255, 65535, 1, 1, 65535, 0);  // top channel, floor at full scale
        add_row(511, 0,   65535, 0, 1, 65535, 1);  // rise capped at peak, below floor
        add_row(511, 0,   65535, 1, 0, 0,     0);
        add_row(2,   0,   1000,  0, 0, 0,     0);
        add_row(2,   0,   2000,  0, 0, 0,     0);  // rise collapses to zero peak, settles
        add_row(2,   0,   2000,  1, 0, 0,     0);
        add_row(2,   0,   3000,  1, 0, 0,     0);  // clamp while capturing is not settled
        add_row(3,   128, 0,     1, 0, 0,     0);
        add_row(3,   0,   0,     0, 0, 0,     0);
        add_row(3,   0,   0,     0, 0, 0,     0);
        add_row(3,   200, 0,     0, 0, 0,     0);  // fader ignored without capture
        add_row(3,   0,   0,     0, 0, 0,     0);
        add_row(3,   1,   0,     1, 0, 0,     0);  // fader below level, no capture
        add_row(4,   128, 40000, 1, 0, 0,     0);
        add_row(4,   0,   40000, 0, 0, 0,     0);
        add_row(170, 85,  43690, 1, 0, 0,     0);
        add_row(341, 170, 21845, 1, 0, 0,     0);
        add_row(0,   255, 0,     0, 0, 0,     0);
        foreach (dir_rows[r])
            send_tick(dir_rows[r].t, dir_rows[r].typed, dir_rows[r].want);
        i_in_valid <= 1'b0;
        wait_drained();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: load_config(16'd300, 16'd40, 16'd2048);
                1: load_config(16'd0, 16'd0, 16'd0);
                2: load_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: load_config(16'd0, 16'd40000, 16'd0);   // speed runs into saturation
                4: load_config(LEVEL_W'($urandom_range(0, 2000)),
                               LEVEL_W'($urandom_range(0, 500)),
                               LEVEL_W'($urandom_range(0, 30000)));
                default: load_config(ble_pkg::STEP_BASE_RST, ble_pkg::SPEED_INCREMENT_RST,
                                     ble_pkg::REBOUND_LOSS_RST);
            endcase
            if (ph < 2) begin
                send_idle_pct  = 12;
                recv_stall_pct = 87;
            end else if (ph < 4) begin
                send_idle_pct  = 87;
                recv_stall_pct = 12;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            // long output hold-off so the pipe fills and backs up the input
            if (ph == PHASES - 1)
                hold_req = 1'b1;
            pick_hot_channels();
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_tick(random_tick(), 1'b0, none);
            i_in_valid <= 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && due_levels.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/ble_pkg.sv
design/ble_state_mem.sv
design/ble_update.sv
design/bouncing_level_envelope.sv
design/ble_checker.sv
verif/bouncing_level_envelope_tb.sv
